>>> hw/rtl/tsa_pkg.sv
// shared types and constants for the timeline slot allocator
// used by tsa_ctrl, tsa_dp and timeline_slot_allocator_top
`timescale 1ns / 1ps
`default_nettype none
package tsa_pkg;

	localparam int TimeBits = 16;
	localparam logic [15:0] CycleReset = 16'd800;

	typedef enum logic [1:0] {
		KIND_ALLOC  = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_EXPIRE = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOWIN    = 3'd1,
		ST_FULL     = 3'd2,
		ST_REMOVED  = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_LOAD = 3'd1,
		OP_DEL  = 3'd2,
		OP_CHK  = 3'd3,
		OP_FIT  = 3'd4,
		OP_DONE = 3'd5
	} op_t;

	typedef struct packed {
		op_t  op;
		logic first;
	} cmd_t;

	typedef struct packed {
		logic is_alloc;
		logic has_free;
		logic win_free;
		logic changed;
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic [TimeBits-1:0] start;
		logic [TimeBits-1:0] stop;
		logic [15:0]         flow;
	} slot_t;

	function automatic logic [2:0] map_queue(input logic [7:0] prio);
		logic [2:0] q;
		begin
			if (prio == 8'd1) q = 3'd7;
			else if (prio == 8'd2) q = 3'd6;
			else if (prio >= 8'd7) q = 3'd0;
			else q = 3'(8'd7 - prio);
			return q;
		end
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/tsa_ctrl.sv
// controller of the slot allocator: request sequencing and table sweeps
// depends on tsa_pkg
`timescale 1ns / 1ps
`default_nettype none
module tsa_ctrl #(
	parameter int MAX_SLOTS = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire tsa_pkg::sts_t                sts,
	output tsa_pkg::cmd_t                     cmd,
	output logic [$clog2(MAX_SLOTS)-1:0]      rd_addr
);
	localparam int AW = $clog2(MAX_SLOTS);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_DEL     = 8'b0000_0010,
		S_DEL_END = 8'b0000_0100,
		S_CHK     = 8'b0000_1000,
		S_CHK_END = 8'b0001_0000,
		S_FIT     = 8'b0010_0000,
		S_FIT_END = 8'b0100_0000,
		S_DONE    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic [AW-1:0] idx_q, idx_d;
	logic last;

	assign last = (idx_q == AW'(MAX_SLOTS - 1));
	assign rd_addr = idx_q;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		cmd.op = tsa_pkg::OP_NONE;
		cmd.first = (idx_q == '0);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = tsa_pkg::OP_LOAD;
					state_d = S_DEL;
					idx_d = '0;
				end
			end
			S_DEL, S_CHK, S_FIT: begin
				if (state_q == S_DEL) cmd.op = tsa_pkg::OP_DEL;
				else if (state_q == S_CHK) cmd.op = tsa_pkg::OP_CHK;
				else cmd.op = tsa_pkg::OP_FIT;
				idx_d = idx_q + AW'(1);
				if (last) begin
					idx_d = '0;
					if (state_q == S_DEL) state_d = S_DEL_END;
					else if (state_q == S_CHK) state_d = S_CHK_END;
					else state_d = S_FIT_END;
				end
			end
			S_DEL_END: begin
				state_d = sts.is_alloc ? S_CHK : S_DONE;
			end
			S_CHK_END: begin
				if (!sts.has_free || sts.win_free) state_d = S_DONE;
				else state_d = S_FIT;
			end
			S_FIT_END: begin
				// keep sweeping until the candidate start settles
				state_d = sts.changed ? S_FIT : S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.op = tsa_pkg::OP_DONE;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/tsa_dp.sv
// datapath of the slot allocator: slot memory, valid bits, search logic,
// counters and result register; depends on tsa_pkg
`timescale 1ns / 1ps
`default_nettype none
module tsa_dp #(
	parameter int MAX_SLOTS = 64
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [15:0]             cfg_wdata,
	input  wire logic [1:0]              kind,
	input  wire logic [15:0]             flow_id,
	input  wire logic [15:0]             arrival_time,
	input  wire logic [15:0]             duration,
	input  wire logic [7:0]              priority_req,
	input  wire logic [15:0]             now_time,
	input  wire tsa_pkg::cmd_t           cmd,
	input  wire logic [$clog2(MAX_SLOTS)-1:0] rd_addr,
	output tsa_pkg::sts_t                sts,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [2:0]                   status,
	output logic [15:0]                  open_time,
	output logic [15:0]                  close_time,
	output logic [2:0]                   queue_index,
	output logic [15:0]                  queuing_delay,
	output logic [6:0]                   removed_count,
	output logic [31:0]                  scheduled_total,
	output logic [31:0]                  dropped_total
);
	localparam int AW = $clog2(MAX_SLOTS);
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int TB = tsa_pkg::TimeBits;

	tsa_pkg::slot_t mem [MAX_SLOTS];
	tsa_pkg::slot_t rd_s1;
	logic [MAX_SLOTS-1:0] valid_q;
	tsa_pkg::op_t op_s1;
	logic first_s1;
	logic [AW-1:0] addr_s1;

	logic [1:0] kind_q;
	logic [15:0] fid_q;
	logic [TB-1:0] arr_q, dur_q, now_q, cand_q, cyc_q;
	logic [2:0] queue_q;
	logic [CW-1:0] removed_q;
	logic has_free_q, win_free_q, changed_q;
	logic [AW-1:0] free_q;
	logic [31:0] sched_q, drop_q;

	logic out_valid_q;
	logic [2:0] status_q, oqueue_q;
	logic [TB-1:0] open_q, close_q, delay_q;
	logic [CW-1:0] oremoved_q;

	logic ent_valid;
	logic [TB:0] win_end, thresh, fit_end;
	logic [TB-1:0] dur_min1;
	logic is_alloc;
	logic chk_free, chk_hit, fit_push;

	assign is_alloc = (kind_q == tsa_pkg::KIND_ALLOC);
	assign ent_valid = valid_q[addr_s1];
	assign win_end = {1'b0, arr_q} + {1'b0, dur_q};
	assign dur_min1 = (dur_q == '0) ? TB'(1) : dur_q;
	assign thresh = {1'b0, cand_q} + {1'b0, dur_min1};
	assign fit_end = {1'b0, cand_q} + {1'b0, dur_q};

	// the last entry of a pass is still in the read stage when the controller decides
	assign chk_free = (op_s1 == tsa_pkg::OP_CHK) && !ent_valid;
	assign chk_hit = (op_s1 == tsa_pkg::OP_CHK) && ent_valid &&
		!(win_end <= {1'b0, rd_s1.start} || arr_q >= rd_s1.stop);
	assign fit_push = (op_s1 == tsa_pkg::OP_FIT) && ent_valid &&
		{1'b0, rd_s1.start} < thresh && rd_s1.stop > cand_q;

	assign sts = '{
		is_alloc: is_alloc,
		has_free: has_free_q || chk_free,
		win_free: win_free_q && !chk_hit,
		changed:  changed_q || fit_push,
		out_free: !out_valid_q || out_ready
	};

	// slot memory, one read and one write port
	always_ff @(posedge clk) begin
		rd_s1 <= mem[rd_addr];
		if (cmd.op == tsa_pkg::OP_DONE && is_alloc && has_free_q &&
		    fit_end <= {1'b0, cyc_q}) begin
			mem[free_q] <= '{start: cand_q, stop: fit_end[TB-1:0], flow: fid_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= tsa_pkg::OP_NONE;
			valid_q <= '0;
			cyc_q <= TB'(tsa_pkg::CycleReset);
			sched_q <= '0;
			drop_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			op_s1 <= cmd.op;
			if (cfg_we) cyc_q <= TB'(cfg_wdata);
			if (cmd.op == tsa_pkg::OP_DONE) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			case (op_s1)
				tsa_pkg::OP_DEL: begin
					if (ent_valid &&
					    (((kind_q == tsa_pkg::KIND_ALLOC || kind_q == tsa_pkg::KIND_REMOVE) &&
					      rd_s1.flow == fid_q) ||
					     (kind_q == tsa_pkg::KIND_EXPIRE && rd_s1.stop < now_q))) begin
						valid_q[addr_s1] <= 1'b0;
					end
				end
				default: begin
				end
			endcase

			if (cmd.op == tsa_pkg::OP_DONE) begin
				if (is_alloc) begin
					if (!has_free_q) drop_q <= drop_q + 32'd1;
					else if (fit_end > {1'b0, cyc_q}) drop_q <= drop_q + 32'd1;
					else begin
						sched_q <= sched_q + 32'd1;
						valid_q[free_q] <= 1'b1;
					end
				end
			end
		end
	end

	// request fields, search state and result payload
	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		addr_s1 <= rd_addr;
		case (cmd.op)
			tsa_pkg::OP_LOAD: begin
				kind_q <= kind;
				fid_q <= flow_id;
				arr_q <= TB'(arrival_time);
				dur_q <= TB'(duration);
				now_q <= TB'(now_time);
				cand_q <= TB'(arrival_time);
				queue_q <= tsa_pkg::map_queue(priority_req);
				removed_q <= '0;
				has_free_q <= 1'b0;
				win_free_q <= 1'b1;
				changed_q <= 1'b0;
				free_q <= '0;
			end
			tsa_pkg::OP_DONE: begin
				oremoved_q <= removed_q;
				case (kind_q)
					tsa_pkg::KIND_ALLOC: begin
						oqueue_q <= queue_q;
						if (has_free_q && fit_end <= {1'b0, cyc_q}) begin
							status_q <= tsa_pkg::ST_OK;
							open_q <= cand_q;
							close_q <= fit_end[TB-1:0];
							delay_q <= cand_q - arr_q;
						end else begin
							status_q <= has_free_q ? tsa_pkg::ST_NOWIN : tsa_pkg::ST_FULL;
							open_q <= '0;
							close_q <= '0;
							delay_q <= '0;
						end
					end
					default: begin
						oqueue_q <= '0;
						open_q <= '0;
						close_q <= '0;
						delay_q <= '0;
						if (kind_q == tsa_pkg::KIND_REMOVE)
							status_q <= (removed_q != '0) ? tsa_pkg::ST_REMOVED
							                              : tsa_pkg::ST_NOTFOUND;
						else if (kind_q == tsa_pkg::KIND_EXPIRE)
							status_q <= tsa_pkg::ST_REMOVED;
						else
							status_q <= tsa_pkg::ST_NOTFOUND;
					end
				endcase
			end
			default: begin
			end
		endcase

		case (op_s1)
			tsa_pkg::OP_DEL: begin
				if (ent_valid &&
				    (((kind_q == tsa_pkg::KIND_ALLOC || kind_q == tsa_pkg::KIND_REMOVE) &&
				      rd_s1.flow == fid_q) ||
				     (kind_q == tsa_pkg::KIND_EXPIRE && rd_s1.stop < now_q))) begin
					removed_q <= removed_q + CW'(1);
				end
			end
			tsa_pkg::OP_CHK: begin
				if (chk_free && !has_free_q) begin
					has_free_q <= 1'b1;
					free_q <= addr_s1;
				end
				if (chk_hit)
					win_free_q <= 1'b0;
			end
			tsa_pkg::OP_FIT: begin
				// an entry starting too close to the candidate pushes it to its end
				if (fit_push) begin
					cand_q <= rd_s1.stop;
					changed_q <= 1'b1;
				end else if (first_s1) begin
					changed_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign open_time = 16'(open_q);
	assign close_time = 16'(close_q);
	assign queue_index = oqueue_q;
	assign queuing_delay = 16'(delay_q);
	assign removed_count = 7'(oremoved_q);
	assign scheduled_total = sched_q;
	assign dropped_total = drop_q;

endmodule
`default_nettype wire

>>> hw/rtl/timeline_slot_allocator_top.sv
// Timeline slot allocator: keeps reserved intervals of one gate cycle and
// serves allocate, remove and expire requests.
// Input channel in_valid/in_ready carries one request item with kind,
// flow_id, arrival_time, duration, priority_req and now_time. Output channel
// out_valid/out_ready returns one result item per request.
// cfg_we/cfg_wdata writes cycle_time (reset 800).
// Sequencing: a request walks the slot table entry by entry, one entry per cycle
// through the slot memory read port. Remove, expire and unknown kinds make one
// delete pass and then raise out_valid. Allocate adds a free-slot and window
// check pass and, when a free slot exists but the arrival window is taken, one
// or more fit passes, repeated until the candidate start stops moving (at most
// MAX_SLOTS + 1 passes).
// One request is worked on at a time; in_ready is high only while idle.
// A finished result sits in the output register; a new request may be taken
// while it waits, and the next result waits for out_ready before it is loaded.
// Reset clears all valid bits, the counters and the output valid flag; the
// table is usable as soon as reset is released.
// depends on tsa_pkg, tsa_ctrl, tsa_dp
`timescale 1ns / 1ps
`default_nettype none
module timeline_slot_allocator_top #(
	parameter int MAX_SLOTS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [15:0] flow_id,
	input  wire logic [15:0] arrival_time,
	input  wire logic [15:0] duration,
	input  wire logic [7:0]  priority_req,
	input  wire logic [15:0] now_time,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [15:0]      open_time,
	output logic [15:0]      close_time,
	output logic [2:0]       queue_index,
	output logic [15:0]      queuing_delay,
	output logic [6:0]       removed_count,
	output logic [31:0]      scheduled_total,
	output logic [31:0]      dropped_total
);
	tsa_pkg::cmd_t cmd;
	tsa_pkg::sts_t sts;
	logic [$clog2(MAX_SLOTS)-1:0] rd_addr;

	tsa_ctrl #(.MAX_SLOTS(MAX_SLOTS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.sts(sts), .cmd(cmd), .rd_addr(rd_addr)
	);

	tsa_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.kind(kind), .flow_id(flow_id), .arrival_time(arrival_time),
		.duration(duration), .priority_req(priority_req), .now_time(now_time),
		.cmd(cmd), .rd_addr(rd_addr), .sts(sts),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.open_time(open_time), .close_time(close_time), .queue_index(queue_index),
		.queuing_delay(queuing_delay), .removed_count(removed_count),
		.scheduled_total(scheduled_total), .dropped_total(dropped_total)
	);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in work");

	a_grant_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == tsa_pkg::ST_OK |-> close_time >= open_time)
		else $error("granted interval closes before it opens");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != tsa_pkg::ST_OK |-> open_time == 16'd0 &&
		close_time == 16'd0 && queuing_delay == 16'd0)
		else $error("failed request reports a window");

endmodule
`default_nettype wire
